[sv/lps_pkg.sv]
// Shared constants and result codes for the linear probing hash set.
package lps_pkg;

	// Table geometry
	localparam int TABLE_SIZE = 16;
	localparam int KEY_WIDTH  = 32;

	// Key bits on the request channel and key bits kept per slot
	localparam int KEY_IN_W = 32;
	localparam int STORE_W  = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;
	localparam int ENTRY_W  = STORE_W + 1;
	localparam int SLOT_W   = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

	// Result fields
	localparam int STATUS_W   = 2;
	localparam int SLOT_OUT_W = 4;
	localparam int OUT_DATA_W = 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - STATUS_W - SLOT_OUT_W;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd3;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

endpackage

[sv/lps_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module lps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/lps_hash.sv]
// Home slot unit: key modulo table size, registered in the cycle after start.
module lps_hash import lps_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [KEY_IN_W-1:0] key,
	output logic                done,
	output logic [SLOT_W-1:0]   home
);

	logic              done_q;
	logic [SLOT_W-1:0] home_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	// Table size is a power of two, so the remainder reduces to the low key bits
	always_ff @(posedge clk) begin
		if (start) begin
			home_q <= SLOT_W'(key % KEY_IN_W'(TABLE_SIZE));
		end
	end

	assign done = done_q;
	assign home = home_q;

endmodule

[sv/linear_probe_hash_set_top.sv]
// Top level of the linear probing hash set: request capture, probe sequencer, result register.
//
// A set of keys held in an open-addressing table of TABLE_SIZE slots, one RAM
// word per slot holding an occupied flag and the key. Each request carries a
// kind (tuser: 0 insert, 1 search) and a key (tdata). The home slot is the key
// modulo TABLE_SIZE, registered in the cycle after the request is accepted.
// The probe then walks the table upward with wrap-around, one slot per cycle,
// by issuing the read of the next slot while the current slot's word comes
// back from the RAM's single read port. An insert writes the key into the
// first free slot (duplicates are not checked) or answers "full" after a whole
// lap. A search stops on a match, on a free slot, or after a whole lap.
// Every request yields exactly one result: status and slot in m_tdata.
// One request is in flight at a time. After acceptance it passes through the
// hash, probe and emit states before the result is offered; the probe reads P
// slots (1 to TABLE_SIZE) through the RAM read port, and the emit state waits
// while an earlier result has not yet left the output register. The result
// sits in an output register, so the next request may be accepted while an
// earlier result still waits for m_tready. After reset the block runs a
// clearing pass through every RAM slot, resetting every occupied flag, and
// holds s_tready low until it is done.
// The single write of an insert lands before the next request's hash finishes,
// so a probe never reads a slot with a write still pending.
module linear_probe_hash_set_top import lps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [KEY_IN_W-1:0]   s_tdata,   // [31:0] key
	input  logic                  s_tuser,   // [0] kind
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // [1:0] status, [5:2] slot, [7:6] zero
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HASH  = 3'd2;
	localparam logic [2:0] S_PROBE = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);

	logic [2:0]            state_q;
	logic [SLOT_W-1:0]     clr_q;
	logic [SLOT_W-1:0]     cnt_q;
	logic [SLOT_W-1:0]     addr_s1;
	logic                  kind_q;
	logic [STORE_W-1:0]    key_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic [SLOT_OUT_W-1:0] res_slot_q;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic                  hash_start;
	logic                  hash_done;
	logic [SLOT_W-1:0]     hash_home;

	logic                  ram_we;
	logic [SLOT_W-1:0]     ram_waddr;
	logic [ENTRY_W-1:0]    ram_wdata;
	logic [SLOT_W-1:0]     ram_raddr;
	logic [ENTRY_W-1:0]    ram_rdata;

	logic                  rd_occ;
	logic                  rd_match;
	logic                  lap_done;
	logic [SLOT_W-1:0]     next_addr;
	logic                  probe_end;
	logic                  probe_wr;
	logic [STATUS_W-1:0]   res_status;
	logic [SLOT_W-1:0]     res_slot;
	logic                  out_free;

	// Accept a request only between items and after the clearing pass
	assign s_tready   = (state_q == S_IDLE);
	assign hash_start = (state_q == S_IDLE) && s_tvalid;

	lps_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (KEY_IN_W'(s_tdata[STORE_W-1:0])),
		.done   (hash_done),
		.home   (hash_home)
	);

	// Word of the slot at addr_s1 arrives this cycle
	assign rd_occ    = ram_rdata[STORE_W];
	assign rd_match  = rd_occ && (ram_rdata[STORE_W-1:0] == key_q);
	assign lap_done  = (cnt_q == LAST_SLOT);
	assign next_addr = (addr_s1 == LAST_SLOT) ? '0 : addr_s1 + SLOT_W'(1);

	// Decide whether the probe stops on the current slot
	always_comb begin
		probe_end  = 1'b0;
		probe_wr   = 1'b0;
		res_status = ST_MISSING;
		res_slot   = '0;
		if (kind_q == KIND_INSERT) begin
			if (!rd_occ) begin
				probe_end  = 1'b1;
				probe_wr   = 1'b1;
				res_status = ST_INSERTED;
				res_slot   = addr_s1;
			end else if (lap_done) begin
				probe_end  = 1'b1;
				res_status = ST_FULL;
			end
		end else begin
			if (!rd_occ) begin
				probe_end  = 1'b1;
			end else if (rd_match) begin
				probe_end  = 1'b1;
				res_status = ST_FOUND;
				res_slot   = addr_s1;
			end else if (lap_done) begin
				probe_end  = 1'b1;
			end
		end
	end

	// RAM ports: clearing pass or insert on the write side, probe on the read side
	assign ram_we    = (state_q == S_CLEAR) || ((state_q == S_PROBE) && probe_wr);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : addr_s1;
	assign ram_wdata = (state_q == S_CLEAR) ? '0 : {1'b1, key_q};
	assign ram_raddr = (state_q == S_HASH) ? hash_home : next_addr;

	lps_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_SIZE)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_free = !m_tvalid_q || m_tready;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
			addr_s1 <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SLOT_W'(1);
					if (clr_q == LAST_SLOT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					// Read of the home slot issues in this cycle
					if (hash_done) begin
						addr_s1 <= hash_home;
						cnt_q   <= '0;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (probe_end) begin
						state_q <= S_EMIT;
					end else begin
						addr_s1 <= next_addr;
						cnt_q   <= cnt_q + SLOT_W'(1);
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
					clr_q   <= '0;
				end
			endcase
		end
	end

	// Request and result payload
	always_ff @(posedge clk) begin
		if (hash_start) begin
			kind_q <= s_tuser;
			key_q  <= s_tdata[STORE_W-1:0];
		end
		if ((state_q == S_PROBE) && probe_end) begin
			res_status_q <= res_status;
			res_slot_q   <= SLOT_OUT_W'(res_slot);
		end
		if ((state_q == S_EMIT) && out_free) begin
			m_tdata_q <= {{OUT_PAD_W{1'b0}}, res_slot_q, res_status_q};
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == S_EMIT) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_write_owner: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLEAR) || ((state_q == S_PROBE) && (kind_q == KIND_INSERT)))
		else $error("table write outside clearing pass or insert probe");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == S_EMIT))
		else $error("result raised without a finished probe");

	a_hash_timing: assert property (@(posedge clk) disable iff (!arst_n)
		hash_done |-> (state_q == S_HASH))
		else $error("home slot ready outside hash phase");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_HASH))
		else $error("accepted request did not start hashing");

endmodule
